// ===== design/pdb_pkg.sv =====
// shared types and constants for the paced display page buffer
// no dependencies; compiled first
package pdb_pkg;

	localparam int PDB_PAGE_CHARS = 32;

	// input item kinds; code 3 is unused and ignored
	typedef enum logic [1:0] {
		ACT_APPEND = 2'd0,
		ACT_HOME   = 2'd1,
		ACT_TICK   = 2'd2
	} action_t;

	localparam logic KIND_HOME = 1'b0;
	localparam logic KIND_CHAR = 1'b1;

	typedef enum logic {
		CTL_IDLE,
		CTL_FETCH
	} ctl_state_t;

	// controller to datapath
	typedef struct packed {
		logic store_char;
		logic set_reject;
		logic send_home;
		logic fetch_char;
		logic load_char;
	} pdb_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic started;
		logic reject;
		logic full;
		logic pending;
		logic out_free;
	} pdb_status_t;

endpackage

// ===== design/pdb_in_if.sv =====
// input channel: valid/ready handshake carrying one item per beat
// no dependencies
interface pdb_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] action;
	logic [7:0] char_code;

	modport source (output valid, output action, output char_code, input ready);
	modport sink (input valid, input action, input char_code, output ready);
endinterface

// ===== design/pdb_out_if.sv =====
// output channel: valid/ready handshake carrying one display beat
// no dependencies
interface pdb_out_if;
	logic       valid;
	logic       ready;
	logic       out_kind;
	logic [7:0] out_char;

	modport source (output valid, output out_kind, output out_char, input ready);
	modport sink (input valid, input out_kind, input out_char, output ready);
endinterface

// ===== design/pdb_ctrl.sv =====
// controller state machine for the page buffer
// depends on pdb_pkg
module pdb_ctrl
	import pdb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic [1:0]  in_action,
	output logic        in_ready,
	input  pdb_status_t status,
	output pdb_cmd_t    cmd
);

	ctl_state_t state_q, state_d;
	logic       accept;
	action_t    act;

	assign act = action_t'(in_action);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CTL_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		cmd      = '0;
		accept   = 1'b0;
		unique case (state_q)
			CTL_IDLE: begin
				// a tick may produce a beat, so it waits for a free output slot
				in_ready = (act != ACT_TICK) || status.out_free;
				accept   = in_valid && in_ready;
				if (accept) begin
					case (act)
						ACT_APPEND: cmd.store_char = !status.reject && !status.full;
						ACT_HOME:   cmd.set_reject = status.pending;
						ACT_TICK: begin
							if (!status.started) begin
								cmd.send_home = 1'b1;
							end else if (status.pending) begin
								cmd.fetch_char = 1'b1;
								state_d        = CTL_FETCH;
							end
						end
						default: ;
					endcase
				end
			end
			CTL_FETCH: begin
				cmd.load_char = 1'b1;
				state_d       = CTL_IDLE;
			end
			default: state_d = CTL_IDLE;
		endcase
	end

	a_fetch_to_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fetch_char |=> (state_q == CTL_FETCH) && cmd.load_char)
		else $error("fetch not followed by load");

	a_fetch_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == CTL_FETCH) |=> (state_q == CTL_IDLE))
		else $error("fetch state held too long");

endmodule

// ===== design/pdb_datapath.sv =====
// page store, counters, flags and output register of the page buffer
// depends on pdb_pkg and pdb_out_if
module pdb_datapath
	import pdb_pkg::*;
#(
	parameter int PAGE_CHARS = PDB_PAGE_CHARS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [7:0]  char_code,
	input  pdb_cmd_t    cmd,
	output pdb_status_t status,
	pdb_out_if.source   result
);

	localparam int CNT_W  = $clog2(PAGE_CHARS + 1);
	localparam int ADDR_W = $clog2(PAGE_CHARS);

	logic [7:0]       mem [PAGE_CHARS];
	logic [7:0]       rd_data_q;
	logic [CNT_W-1:0] fill_q;
	logic [CNT_W-1:0] draw_q;
	logic             started_q;
	logic             reject_q;
	logic             out_valid_q;
	logic             out_kind_q;
	logic [7:0]       out_char_q;
	logic             last_char;

	assign last_char = (draw_q + CNT_W'(1)) >= fill_q;

	assign status.started  = started_q;
	assign status.reject   = reject_q;
	assign status.full     = fill_q >= CNT_W'(PAGE_CHARS);
	assign status.pending  = fill_q > draw_q;
	assign status.out_free = !out_valid_q || result.ready;

	// page store, no reset: entries are read only below the fill count
	always_ff @(posedge clk) begin
		if (cmd.store_char) begin
			mem[fill_q[ADDR_W-1:0]] <= char_code;
		end
		if (cmd.fetch_char) begin
			rd_data_q <= mem[draw_q[ADDR_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q    <= '0;
			draw_q    <= '0;
			started_q <= 1'b0;
			reject_q  <= 1'b0;
		end else if (cmd.store_char) begin
			fill_q <= fill_q + CNT_W'(1);
		end else if (cmd.set_reject) begin
			reject_q <= 1'b1;
		end else if (cmd.send_home) begin
			started_q <= 1'b1;
			draw_q    <= '0;
		end else if (cmd.fetch_char) begin
			if (last_char) begin
				fill_q    <= '0;
				draw_q    <= '0;
				started_q <= 1'b0;
				reject_q  <= 1'b0;
			end else begin
				draw_q <= draw_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.send_home || cmd.load_char) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.send_home) begin
			out_kind_q <= KIND_HOME;
			out_char_q <= '0;
		end else if (cmd.load_char) begin
			out_kind_q <= KIND_CHAR;
			out_char_q <= rd_data_q;
		end
	end

	assign result.valid    = out_valid_q;
	assign result.out_kind = out_kind_q;
	assign result.out_char = out_char_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(PAGE_CHARS))
		else $error("fill count beyond page size");

	a_draw_bound: assert property (@(posedge clk) disable iff (!arst_n)
		draw_q <= fill_q)
		else $error("draw index ahead of fill count");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.send_home || cmd.load_char) |-> (!out_valid_q || result.ready))
		else $error("output register overwritten while full");

endmodule

// ===== design/paced_display_page_buffer.sv =====
// paced display page buffer: one append, home or tick item per beat in, display beats out
// a cursor-home beat is offered the cycle after its tick is taken; a character beat goes
// through the page store read register and then the output register before it is offered
// items go in at one per cycle, but a tick waits while the output register is still full,
// and a character tick holds the input in the fetch state while the store read lands
// reset: counters and flags clear at once, the page store is left as it is (no sweep)
module paced_display_page_buffer
	import pdb_pkg::*;
#(
	parameter int PAGE_CHARS = PDB_PAGE_CHARS
) (
	input  logic      clk,
	input  logic      arst_n,
	pdb_in_if.sink    item,
	pdb_out_if.source result
);

	// command and status between the state machine and the datapath
	pdb_cmd_t    cmd;
	pdb_status_t status;

	// controller decides what each accepted beat does from the page status;
	// ticks are held back while the output register cannot take a new beat
	pdb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item.valid),
		.in_action (item.action),
		.in_ready  (item.ready),
		.status    (status),
		.cmd       (cmd)
	);

	// datapath holds the page store, fill and draw counters, the started and
	// reject flags, and the output register that parts the two channels
	pdb_datapath #(
		.PAGE_CHARS (PAGE_CHARS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.char_code (item.char_code),
		.cmd       (cmd),
		.status    (status),
		.result    (result)
	);

endmodule

// ===== tb/tb_top.sv =====
// self-checking bench for the paced display page buffer: random item stream in, display beats out
// depends on pdb_pkg, pdb_in_if, pdb_out_if and the paced_display_page_buffer top level
module tb_top;
	import pdb_pkg::*;

	// code 3 on the action field has no member in the package enum
	localparam logic [1:0] ACT_UNUSED = 2'd3;
	localparam int         RANDOM_ITEMS = 550;
	localparam int         HOLD_AFTER = 150;   // items taken before the long receiver hold-off
	localparam int         HOLD_CYCLES = 250;
	localparam int         DRAIN_CYCLES = 8;

	typedef struct packed {
		logic [1:0] action;
		logic [7:0] code;
	} page_item_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] ch;
	} display_beat_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	always #2 clk = ~clk;

	// bench-side copies of the channel inputs, known from time zero
	logic       in_valid = 1'b0;
	logic [1:0] in_action = ACT_APPEND;
	logic [7:0] in_code = 8'h00;
	logic       out_ready = 1'b0;

	pdb_in_if  in_ch ();
	pdb_out_if out_ch ();

	assign in_ch.valid     = in_valid;
	assign in_ch.action    = in_action;
	assign in_ch.char_code = in_code;
	assign out_ch.ready    = out_ready;

	paced_display_page_buffer dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (in_ch.sink),
		.result (out_ch.source)
	);

	// items waiting to be offered, and display beats the page model says must come out
	page_item_t    pending_items[$];
	display_beat_t display_expect[$];

	// page model state at the block's own widths
	logic [7:0] page_store [0:PDB_PAGE_CHARS-1];
	logic [5:0] fill_count = '0;
	logic [5:0] draw_index = '0;
	logic       draw_started = 1'b0;
	logic       reject_flag = 1'b0;

	int unsigned errors = 0;
	int unsigned taken_count = 0;
	int unsigned cycle_count = 0;
	logic        in_taken = 1'b0;
	int unsigned in_gap = 0;
	int unsigned out_stall = 0;
	int unsigned hold_left = 0;
	logic        hold_done = 1'b0;

	// empty the page: counters back to zero, next tick sends cursor-home again
	task automatic clear_page();
		fill_count   = '0;
		draw_index   = '0;
		draw_started = 1'b0;
		reject_flag  = 1'b0;
	endtask

	// apply one accepted item to the page model, queue the display beat it causes
	task automatic advance_page(input logic [1:0] act, input logic [7:0] code);
		display_beat_t beat;
		case (act)
			ACT_APPEND: begin
				// dropped silently while rejecting or once the store is full
				if (!reject_flag && fill_count < PDB_PAGE_CHARS) begin
					page_store[fill_count] = code;
					fill_count = fill_count + 6'd1;
				end
			end
			ACT_HOME: begin
				// a page already fully drawn (or empty) ignores the request
				if (fill_count > draw_index)
					reject_flag = 1'b1;
			end
			ACT_TICK: begin
				if (!draw_started) begin
					// cursor-home goes out first, even on an empty page
					draw_started = 1'b1;
					draw_index   = '0;
					beat.kind    = KIND_HOME;
					beat.ch      = 8'h00;
					display_expect.push_back(beat);
				end else if (draw_index < fill_count && draw_index < PDB_PAGE_CHARS) begin
					beat.kind = KIND_CHAR;
					beat.ch   = page_store[draw_index];
					display_expect.push_back(beat);
					draw_index = draw_index + 6'd1;
					if (draw_index >= fill_count)
						clear_page();
				end
			end
			default: ;   // unused code: no beat, no state change
		endcase
	endtask

	// idle lengths: mostly short, now and then long, none at all in calm stretches
	function automatic int unsigned pick_gap();
		int unsigned r;
		if (cycle_count[8:7] == 2'b00)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	task automatic queue_item(input logic [1:0] act, input logic [7:0] code);
		page_item_t it;
		it.action = act;
		it.code   = code;
		pending_items.push_back(it);
	endtask

	function automatic logic [7:0] pick_code();
		if ($urandom_range(0, 9) == 0)
			return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
		return 8'($urandom_range(0, 255));
	endfunction

	// stimulus: directed walk through the special cases, then random page traffic
	initial begin : build_stimulus
		int unsigned counted;
		int unsigned r;
		int unsigned n;
		int unsigned k;

		// tick on an empty page sends cursor-home, the next one sends nothing
		queue_item(ACT_TICK, 8'h00);
		queue_item(ACT_TICK, 8'h00);
		// home request on a finished page has no effect
		queue_item(ACT_HOME, 8'h00);
		// unused action code is ignored
		queue_item(ACT_UNUSED, 8'hFF);
		// character code zero and the top code go through like any other byte
		queue_item(ACT_APPEND, 8'h00);
		queue_item(ACT_APPEND, 8'hFF);
		queue_item(ACT_TICK, 8'h00);
		queue_item(ACT_TICK, 8'h00);
		queue_item(ACT_TICK, 8'h00);
		// home request mid-page sets the reject flag, the next append is dropped
		queue_item(ACT_APPEND, 8'h5A);
		queue_item(ACT_APPEND, 8'h3C);
		queue_item(ACT_TICK, 8'h00);
		queue_item(ACT_HOME, 8'h00);
		queue_item(ACT_APPEND, 8'h77);
		queue_item(ACT_TICK, 8'h00);
		// home request on a page still being drawn with the reject flag already set
		queue_item(ACT_APPEND, 8'h11);
		queue_item(ACT_HOME, 8'h00);
		queue_item(ACT_APPEND, 8'h22);
		queue_item(ACT_TICK, 8'h00);
		queue_item(ACT_TICK, 8'h00);
		queue_item(ACT_APPEND, 8'h80);
		queue_item(ACT_APPEND, 8'h01);
		queue_item(ACT_TICK, 8'h00);
		queue_item(ACT_TICK, 8'h00);
		queue_item(ACT_TICK, 8'h00);

		counted = 0;
		while (counted < RANDOM_ITEMS) begin
			r = $urandom_range(0, 9);
			if (r < 6) begin
				// a whole page: fill, then draw it out with the odd stray item mixed in
				k = $urandom_range(0, 99);
				if (k < 80)
					n = $urandom_range(1, 10);
				else if (k < 90)
					n = $urandom_range(28, 32);
				else
					n = $urandom_range(33, 40);   // runs into the full store
				for (int i = 0; i < n; i++)
					queue_item(ACT_APPEND, pick_code());
				for (int i = 0; i < n + 2; i++) begin
					queue_item(ACT_TICK, 8'h00);
					k = $urandom_range(0, 15);
					if (k == 0)
						queue_item(ACT_HOME, pick_code());
					else if (k == 1)
						queue_item(ACT_APPEND, pick_code());
				end
				counted += 2 * n + 2;
			end else if (r < 8) begin
				// broken page: home request part way through, later appends dropped
				n = $urandom_range(1, 6);
				for (int i = 0; i < n; i++)
					queue_item(ACT_APPEND, pick_code());
				for (int i = 0; i < n / 2; i++)
					queue_item(ACT_TICK, 8'h00);
				queue_item(ACT_HOME, pick_code());
				k = $urandom_range(1, 4);
				for (int i = 0; i < k; i++)
					queue_item(ACT_APPEND, pick_code());
				for (int i = 0; i < n + 2; i++)
					queue_item(ACT_TICK, 8'h00);
				counted += n + n / 2 + n + 3;
			end else begin
				// noise: any action code, any byte
				n = $urandom_range(1, 6);
				for (int i = 0; i < n; i++) begin
					k = $urandom_range(0, 3);
					queue_item(2'(k), 8'($urandom_range(0, 255)));
					if (2'(k) != ACT_UNUSED)
						counted++;
				end
			end
		end
	end

	// one reset pulse at the start, released on a falling edge
	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// monitor: sample both channels at the rising edge, check beats, feed the page model
	always @(posedge clk) begin : watch_ports
		display_beat_t got;
		display_beat_t want;
		cycle_count = cycle_count + 1;
		in_taken = arst_n && in_ch.valid && in_ch.ready;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got.kind = out_ch.out_kind;
			got.ch   = out_ch.out_char;
			if (display_expect.size() == 0) begin
				errors++;
				$display("%0t: display beat kind %0b char %02h with nothing expected",
					$time, got.kind, got.ch);
			end else begin
				want = display_expect.pop_front();
				if (got.kind !== want.kind) begin
					errors++;
					$display("%0t: out_kind expected %0b actual %0b", $time, want.kind, got.kind);
				end
				if (got.ch !== want.ch) begin
					errors++;
					$display("%0t: out_char expected %02h actual %02h", $time, want.ch, got.ch);
				end
			end
		end
		// a beat taken at this edge can only show up at a later one
		if (in_taken) begin
			advance_page(in_ch.action, in_ch.char_code);
			taken_count++;
		end
	end

	// driver: offer the next pending item on the falling edge once the last one was taken
	always @(negedge clk) begin : drive_items
		logic       nv;
		logic [1:0] na;
		logic [7:0] nc;
		page_item_t it;
		nv = in_valid;
		na = in_action;
		nc = in_code;
		if (arst_n && (!in_valid || in_taken)) begin
			nv = 1'b0;
			// during the receiver hold-off keep offering so the block backs up
			if (in_gap != 0 && hold_left == 0) begin
				in_gap = in_gap - 1;
			end else if (pending_items.size() != 0) begin
				it = pending_items.pop_front();
				nv = 1'b1;
				na = it.action;
				nc = it.code;
				in_gap = pick_gap();
			end
		end
		in_valid  <= nv;
		in_action <= na;
		in_code   <= nc;
	end

	// long receiver hold-off, counted here once enough items have gone in
	always @(negedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (!hold_done && taken_count >= HOLD_AFTER) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end
	end

	// receiver: random stalls on top of the hold-off
	always @(negedge clk) begin : drive_ready
		logic nr;
		if (!arst_n || hold_left != 0) begin
			nr = 1'b0;
		end else if (out_stall != 0) begin
			out_stall = out_stall - 1;
			nr = 1'b0;
		end else begin
			nr = 1'b1;
			if ($urandom_range(0, 3) == 0)
				out_stall = pick_gap();
		end
		out_ready <= nr;
	end

	// end of run: all items in, all beats out, then a short drain for strays
	initial begin
		@(posedge arst_n);
		while (pending_items.size() != 0 || in_valid)
			@(posedge clk);
		while (display_expect.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && display_expect.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#2_000_000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule

// ===== paced_display_page_buffer.f =====
design/pdb_pkg.sv
design/pdb_in_if.sv
design/pdb_out_if.sv
design/pdb_ctrl.sv
design/pdb_datapath.sv
design/paced_display_page_buffer.sv
tb/tb_top.sv
